@@ src/npc_pkg.sv @@
// Shared types, constants and distance helpers for the nearest palette color search.
// No dependencies; used by npc_ctrl, npc_dp and nearest_palette_color_l1.
`timescale 1ns / 1ps

package npc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int SEARCH_COUNT_DEF  = 255;

    localparam int COLOR_W = 24;
    localparam int INDEX_W = 8;
    localparam int CHAN_W  = 8;
    localparam int DIST_W  = 10;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic start;
        logic wr_en;
        logic rd_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } sts_t;

    function automatic logic [CHAN_W-1:0] chan_diff(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [DIST_W-1:0] color_distance(
        input logic [COLOR_W-1:0] p,
        input logic [COLOR_W-1:0] q
    );
        logic [DIST_W-1:0] dr;
        logic [DIST_W-1:0] dg;
        logic [DIST_W-1:0] db;
        dr = DIST_W'(chan_diff(p[7:0], q[7:0]));
        dg = DIST_W'(chan_diff(p[15:8], q[15:8]));
        db = DIST_W'(chan_diff(p[23:16], q[23:16]));
        return dr + dg + db;
    endfunction

endpackage

@@ src/npc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/npc_ctrl.sv @@
// Search controller: accepts transfers, sequences palette reads, hands off results.
// Depends on npc_pkg.
`timescale 1ns / 1ps

module npc_ctrl #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF,
    parameter int SEARCH_COUNT  = npc_pkg::SEARCH_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_valid,
    input  logic                             req_type,
    input  logic [npc_pkg::INDEX_W-1:0]      entry_index,
    output logic                             s_ready,
    output npc_pkg::cmd_t                    cmd,
    output logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
    input  npc_pkg::sts_t                    sts
);

    localparam int ADDR_W     = $clog2(PALETTE_DEPTH);
    localparam int SEARCH_EFF = (SEARCH_COUNT < PALETTE_DEPTH) ? SEARCH_COUNT : PALETTE_DEPTH;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic              in_range;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_range = ({1'b0, entry_index} < (npc_pkg::INDEX_W + 1)'(PALETTE_DEPTH));
    assign rd_addr  = cnt_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.start    = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    if (req_type == npc_pkg::REQ_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.wr_en = in_range;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == ADDR_W'(SEARCH_EFF - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ src/npc_dp.sv @@
// Search datapath: palette memory, distance stage, running minimum, output register.
// Depends on npc_pkg and npc_ram.
`timescale 1ns / 1ps

module npc_dp #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  npc_pkg::cmd_t                    cmd,
    input  logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
    input  logic [npc_pkg::INDEX_W-1:0]      entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]      entry_color,
    input  logic [npc_pkg::COLOR_W-1:0]      pixel_color,
    output npc_pkg::sts_t                    sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [npc_pkg::INDEX_W-1:0]      out_index
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);

    logic [npc_pkg::COLOR_W-1:0] rd_data;
    logic [npc_pkg::COLOR_W-1:0] pixel_reg;

    // read stage
    logic              va_reg;
    logic [ADDR_W-1:0] aidx_reg;

    // distance stage
    logic                       vb_reg;
    logic [ADDR_W-1:0]          bidx_reg;
    logic [npc_pkg::DIST_W-1:0] dist_reg;

    // running minimum
    logic                       found_reg;
    logic                       found_next;
    logic [npc_pkg::DIST_W-1:0] best_d_reg;
    logic [npc_pkg::DIST_W-1:0] best_d_next;
    logic [ADDR_W-1:0]          best_idx_reg;
    logic [ADDR_W-1:0]          best_idx_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [npc_pkg::INDEX_W-1:0] out_index_reg;

    npc_ram #(
        .WIDTH (npc_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (entry_index[ADDR_W-1:0]),
        .wr_data (entry_color),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        found_next    = found_reg;
        best_d_next   = best_d_reg;
        best_idx_next = best_idx_reg;
        if (cmd.start)
        begin
            found_next = 1'b0;
        end
        else if (vb_reg && (!found_reg || (dist_reg < best_d_reg)))
        begin
            found_next    = 1'b1;
            best_d_next   = dist_reg;
            best_idx_next = bidx_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            va_reg        <= cmd.rd_en;
            vb_reg        <= va_reg;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pixel_reg <= pixel_color;
        end
        if (cmd.rd_en)
        begin
            aidx_reg <= rd_addr;
        end
        if (va_reg)
        begin
            dist_reg <= npc_pkg::color_distance(pixel_reg, rd_data);
            bidx_reg <= aidx_reg;
        end
        best_d_reg   <= best_d_next;
        best_idx_reg <= best_idx_next;
        if (cmd.load_out)
        begin
            out_index_reg <= npc_pkg::INDEX_W'(best_idx_reg);
        end
    end

    assign sts.busy     = va_reg | vb_reg;
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;

endmodule

@@ src/nearest_palette_color_l1.sv @@
// Top level of the nearest palette color search (L1 distance).
// Depends on npc_pkg, npc_ctrl, npc_dp (which holds npc_ram).
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-------------------------------------------
//   s       | in        | s_tvalid/s_tready | tuser: req_type; tdata: index, color, pixel
//   m       | out       | m_tvalid/m_tready | tdata: nearest_index (queries only)
//
// A load writes its entry into the palette on the accepting edge.
// A query reads min(SEARCH_COUNT, PALETTE_DEPTH) entries through the single palette
// read port (one entry per cycle), passes them through the distance and compare stages,
// then loads the output register; the next transfer is taken after that.
// A stalled result holds the block only when a following query finishes before it drains.
// Reset clears control state only; palette contents are undefined until loaded.
`timescale 1ns / 1ps

module nearest_palette_color_l1 #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF,
    parameter int SEARCH_COUNT  = npc_pkg::SEARCH_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // entry_index[7:0], entry_color[31:8], pixel_color[55:32]
    input  logic        s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // nearest_index
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);

    npc_pkg::cmd_t     cmd;
    npc_pkg::sts_t     sts;
    logic [ADDR_W-1:0] rd_addr;

    npc_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH),
        .SEARCH_COUNT  (SEARCH_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_tvalid),
        .req_type    (s_tuser),
        .entry_index (s_tdata[7:0]),
        .s_ready     (s_tready),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .sts         (sts)
    );

    npc_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .entry_index (s_tdata[7:0]),
        .entry_color (s_tdata[31:8]),
        .pixel_color (s_tdata[55:32]),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_index   (m_tdata)
    );

endmodule

@@ bench/nearest_palette_color_l1_tb.sv @@
// Self-checking bench for nearest_palette_color_l1: fills the palette, runs directed
// and random load/query transfers with random idle and stall bursts, checks each index.
// Depends on npc_pkg and the nearest_palette_color_l1 RTL.
`timescale 1ns / 1ps

class nearest_color_scoreboard_t;
    localparam int DEPTH = npc_pkg::PALETTE_DEPTH_DEF;
    localparam int SCAN  = (npc_pkg::SEARCH_COUNT_DEF < DEPTH) ?
                           npc_pkg::SEARCH_COUNT_DEF : DEPTH;
    localparam bit [7:0] NO_ENTRY = 8'hFF;

    bit [23:0] palette [DEPTH];
    bit [7:0]  expected_idx [$];
    int        mismatches;

    function int l1_distance(bit [23:0] a, bit [23:0] b);
        int d;
        int x;
        int y;
        d = 0;
        for (int c = 0; c < 24; c += 8)
        begin
            x = a[c +: 8];
            y = b[c +: 8];
            d += (x > y) ? x - y : y - x;
        end
        return d;
    endfunction

    function bit [7:0] nearest_entry(bit [23:0] pix);
        bit [7:0] best;
        int       best_d;
        int       d;
        best = NO_ENTRY;
        best_d = 0;
        for (int i = 0; i < SCAN; i++)
        begin
            d = l1_distance(pix, palette[i]);
            if (i == 0 || d < best_d)
            begin
                best_d = d;
                best = i[7:0];
            end
        end
        return best;
    endfunction

    function void note_transfer(logic req, logic [7:0] idx, logic [23:0] ecol,
                                logic [23:0] pix);
        if (req == npc_pkg::REQ_LOAD)
        begin
            if (int'(idx) < DEPTH)
                palette[idx] = ecol;
        end
        else
        begin
            expected_idx.push_back(nearest_entry(pix));
        end
    endfunction

    function void check_result(logic [7:0] got);
        bit [7:0] want;
        if (expected_idx.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transfer: nearest_index %0d", got);
            return;
        end
        want = expected_idx.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("nearest_index mismatch: expected %0d, actual %0d", want, got);
        end
    endfunction

    function int pending();
        return expected_idx.size();
    endfunction
endclass

module nearest_palette_color_l1_tb;

    localparam int DEPTH = npc_pkg::PALETTE_DEPTH_DEF;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;  // entry_index[7:0], entry_color[31:8], pixel_color[55:32]
    logic        s_tuser;  // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;  // nearest_index

    nearest_color_scoreboard_t sb = new;
    bit idle_on;
    int stall_left;

    nearest_palette_color_l1 #(
        .PALETTE_DEPTH (npc_pkg::PALETTE_DEPTH_DEF),
        .SEARCH_COUNT  (npc_pkg::SEARCH_COUNT_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic send_item(logic req, logic [7:0] idx, logic [23:0] ecol,
                             logic [23:0] pix);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pix, ecol, idx};
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_transfer(req, idx, ecol, pix);
    endtask

    // result side: check on each transfer, stall in bursts
    initial
    begin
        m_tready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_result(m_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 12) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [7:0]  idx;
        logic [23:0] col;
        logic [23:0] pix;
        bit   [23:0] base;
        s_tvalid <= 1'b0;
        s_tuser  <= npc_pkg::REQ_LOAD;
        s_tdata  <= '0;
        rst_n    <= 1'b0;
        idle_on = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every slot written before any query
        idle_on = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            send_item(npc_pkg::REQ_LOAD, i[7:0], 24'($urandom), 24'($urandom));

        // extremes, ties, and the never-searched last slot
        send_item(npc_pkg::REQ_LOAD,  8'd0,   24'h000000, 24'hFFFFFF);
        send_item(npc_pkg::REQ_LOAD,  8'd254, 24'hFFFFFF, 24'h000000);
        send_item(npc_pkg::REQ_LOAD,  8'd255, 24'h40C020, 24'hFFFFFF);
        send_item(npc_pkg::REQ_LOAD,  8'd10,  24'h808080, 24'h000000);
        send_item(npc_pkg::REQ_LOAD,  8'd20,  24'h808080, 24'h000000);
        send_item(npc_pkg::REQ_LOAD,  8'd30,  24'h0000FF, 24'h000000);
        send_item(npc_pkg::REQ_QUERY, 8'hFF,  24'hFFFFFF, 24'h000000);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'hFFFFFF);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'h40C020);
        send_item(npc_pkg::REQ_QUERY, 8'hFF,  24'hFFFFFF, 24'h808080);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'h7F8081);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'h0000FF);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'hFF0000);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'h00FF00);
        send_item(npc_pkg::REQ_LOAD,  8'd10,  24'h818181, 24'h000000);
        send_item(npc_pkg::REQ_QUERY, 8'h00,  24'h000000, 24'h808080);

        for (int n = 0; n < 978; n++)
        begin
            if (n % 100 == 0)
                idle_on = (n < 850) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 45)
            begin
                base = sb.palette[$urandom_range(0, DEPTH - 1)];
                case ($urandom_range(0, 2))
                    0: pix = base;
                    1: pix = base ^ (24'($urandom) & 24'h0F0F0F);
                    default: pix = 24'($urandom);
                endcase
                send_item(npc_pkg::REQ_QUERY, 8'($urandom), 24'($urandom), pix);
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0: idx = 8'd0;
                    1: idx = 8'd254;
                    2: idx = 8'd255;
                    default: idx = 8'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2: col = sb.palette[$urandom_range(0, DEPTH - 1)];
                    3: col = 24'h000000;
                    4: col = 24'hFFFFFF;
                    default: col = 24'($urandom);
                endcase
                send_item(npc_pkg::REQ_LOAD, idx, col, 24'($urandom));
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #25ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ nearest_palette_color_l1.f @@
src/npc_pkg.sv
src/npc_ram.sv
src/npc_ctrl.sv
src/npc_dp.sv
src/nearest_palette_color_l1.sv
bench/nearest_palette_color_l1_tb.sv
